>>> sv/lasu_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constant tables for the linear attention state update block.
// No dependencies.
package lasu_pkg;

  typedef enum logic [1:0] {
    ACT_KEY   = 2'd0,
    ACT_VALUE = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    RULE_LINEAR      = 2'd0,
    RULE_GATED       = 2'd1,
    RULE_DELTA       = 2'd2,
    RULE_GATED_DELTA = 2'd3
  } rule_e;

  typedef enum logic [2:0] {
    REG_RULE          = 3'd0,
    REG_DECAY_PER_KEY = 3'd1,
    REG_KEY_SIZE      = 3'd2,
    REG_VALUE_SIZE    = 3'd3,
    REG_HEADS         = 3'd4,
    REG_SCALE         = 3'd5
  } reg_e;

  localparam logic [24:0] FRAC_ONE = 25'd16777216;

  typedef struct packed {
    logic wr_key;
    logic wr_value;
    logic wr_query;
    logic clr;
    logic rd_en;
    logic first;
    logic p_decay;
    logic p_acc;
    logic p_update;
    logic use_query;
    logic d_diff;
    logic d_mul;
    logic d_store;
    logic o_round;
    logic o_mul;
    logic o_load;
  } cmd_t;

  typedef struct packed {
    logic dec_busy;
    logic out_free;
  } sts_t;

  function automatic logic [16:0] exp_int_q16(input logic [3:0] n);
    logic [16:0] r;
    case (n)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd24109;
      4'd2:    r = 17'd8869;
      4'd3:    r = 17'd3263;
      4'd4:    r = 17'd1200;
      4'd5:    r = 17'd442;
      4'd6:    r = 17'd162;
      4'd7:    r = 17'd60;
      4'd8:    r = 17'd22;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // Reciprocal ceil(2^28 / k), exact for 24-bit dividends.
  function automatic logic [28:0] recip_q28(input logic [3:0] k);
    logic [28:0] r;
    case (k)
      4'd1:    r = 29'd268435456;
      4'd2:    r = 29'd134217728;
      4'd3:    r = 29'd89478486;
      4'd4:    r = 29'd67108864;
      4'd5:    r = 29'd53687092;
      4'd6:    r = 29'd44739243;
      4'd7:    r = 29'd38347923;
      4'd8:    r = 29'd33554432;
      default: r = 29'd0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/lasu_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lasu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/lasu_decay.sv
`timescale 1ns / 1ps
// Iterative decay factor unit: exp(g) in Q1.16 from a Q4.12 log decay.
// Depends on lasu_pkg.
module lasu_decay
  import lasu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] g_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [16:0]        factor_o
);

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_MUL  = 4'b0010,
    D_DIV  = 4'b0100,
    D_FIN  = 4'b1000
  } dec_state_e;

  dec_state_e  state_q, state_d;
  logic [3:0]  k_q, k_d;
  logic [3:0]  n_q;
  logic [23:0] x_q;
  logic [24:0] t_q;
  logic [47:0] p_q;
  logic [15:0] d_w;
  logic [52:0] qp_w;
  logic [41:0] fp_w;
  logic [42:0] fr_w;

  // The Horner series runs one multiply and one reciprocal multiply per term.
  assign d_w  = 16'(17'd0 - 17'($signed(g_i)));
  assign qp_w = 53'(p_q[47:24]) * 53'(recip_q28(k_q));
  assign fp_w = 42'(exp_int_q16(n_q)) * 42'(t_q);
  assign fr_w = 43'(fp_w) + 43'd8388608;

  assign busy_o   = (state_q != D_IDLE);
  assign done_o   = (state_q == D_FIN);
  assign factor_o = fr_w[40:24];

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    case (state_q)
      D_IDLE: begin
        if (start_i) begin
          k_d     = 4'd8;
          state_d = g_i[15] ? D_MUL : D_FIN;
        end
      end
      D_MUL: state_d = D_DIV;
      D_DIV: begin
        k_d     = k_q - 4'd1;
        state_d = (k_q == 4'd1) ? D_FIN : D_MUL;
      end
      D_FIN:   state_d = D_IDLE;
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      k_q     <= 4'd0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == D_IDLE && start_i) begin
      t_q <= FRAC_ONE;
      if (g_i[15]) begin
        n_q <= d_w[15:12];
        x_q <= {d_w[11:0], 12'd0};
      end else begin
        n_q <= 4'd0;
        x_q <= 24'd0;
      end
    end
    if (state_q == D_MUL) begin
      p_q <= 48'(x_q) * 48'(t_q);
    end
    if (state_q == D_DIV) begin
      t_q <= FRAC_ONE - qp_w[52:28];
    end
  end

endmodule

>>> sv/lasu_ctrl.sv
`timescale 1ns / 1ps
// Controller: decodes accepted words and sequences row passes and column steps.
// Depends on lasu_pkg.
module lasu_ctrl
  import lasu_pkg::*;
#(
  parameter int unsigned DK = 16,
  parameter int unsigned DV = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_fire_i,
  input  action_e                                action_i,
  input  logic [5:0]                             idx_i,
  input  logic [1:0]                             head_i,
  input  logic [1:0]                             rule_i,
  input  logic [6:0]                             kd_i,
  input  logic [6:0]                             vd_i,
  input  logic [2:0]                             hg_i,
  input  sts_t                                   sts_i,
  output logic                                   ready_o,
  output cmd_t                                   cmd_o,
  output logic [((DK > 1) ? $clog2(DK) : 1)-1:0] row_rd_o,
  output logic [((DK > 1) ? $clog2(DK) : 1)-1:0] row_proc_o,
  output logic [((DV > 1) ? $clog2(DV) : 1)-1:0] col_o
);

  localparam int unsigned KW = (DK > 1) ? $clog2(DK) : 1;
  localparam int unsigned VW = (DV > 1) ? $clog2(DV) : 1;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DECAY  = 11'b000_0000_0010,
    S_RETR   = 11'b000_0000_0100,
    S_DDIFF  = 11'b000_0000_1000,
    S_DMUL   = 11'b000_0001_0000,
    S_DSTORE = 11'b000_0010_0000,
    S_UPDATE = 11'b000_0100_0000,
    S_QACC   = 11'b000_1000_0000,
    S_OROUND = 11'b001_0000_0000,
    S_OMUL   = 11'b010_0000_0000,
    S_OLOAD  = 11'b100_0000_0000
  } ctrl_state_e;

  ctrl_state_e    state_q, state_d;
  logic [6:0]     cnt_q, cnt_d, cnt_m1;
  logic [VW-1:0]  col_q, col_d;
  logic           gated, delta, pass_rd, pass_end, proc, col_last;
  logic [6:0]     idx7;

  assign gated    = (rule_i == RULE_GATED) || (rule_i == RULE_GATED_DELTA);
  assign delta    = (rule_i == RULE_DELTA) || (rule_i == RULE_GATED_DELTA);
  assign idx7     = {1'b0, idx_i};
  assign pass_rd  = (cnt_q < kd_i);
  assign pass_end = (cnt_q == kd_i);
  assign proc     = (cnt_q != 7'd0);
  assign cnt_m1   = cnt_q - 7'd1;
  assign col_last = (7'(col_q) == (vd_i - 7'd1));

  assign row_rd_o   = cnt_q[KW-1:0];
  assign row_proc_o = cnt_m1[KW-1:0];
  assign col_o      = col_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    col_d   = col_q;
    cmd_o   = '0;
    ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        ready_o = !sts_i.dec_busy;
        cnt_d   = 7'd0;
        col_d   = '0;
        if (in_fire_i) begin
          case (action_i)
            ACT_KEY: begin
              cmd_o.wr_key = (idx7 < kd_i);
            end
            ACT_VALUE: begin
              if (idx7 < vd_i) begin
                cmd_o.wr_value = 1'b1;
                if (idx7 == vd_i - 7'd1) begin
                  state_d = gated ? S_DECAY : (delta ? S_RETR : S_UPDATE);
                end
              end
            end
            ACT_QUERY: begin
              if ((idx7 < kd_i) && ({1'b0, head_i} < hg_i)) begin
                cmd_o.wr_query = 1'b1;
                if (idx7 == kd_i - 7'd1) begin
                  state_d = S_QACC;
                end
              end
            end
            ACT_CLEAR: cmd_o.clr = 1'b1;
            default: ;
          endcase
        end
      end
      S_DECAY: begin
        cmd_o.rd_en   = pass_rd;
        cmd_o.p_decay = proc;
        cnt_d         = cnt_q + 7'd1;
        if (pass_end) begin
          cnt_d   = 7'd0;
          state_d = delta ? S_RETR : S_UPDATE;
        end
      end
      S_RETR: begin
        cmd_o.rd_en = pass_rd;
        cmd_o.p_acc = proc;
        cmd_o.first = (cnt_q == 7'd1);
        cnt_d       = cnt_q + 7'd1;
        if (pass_end) begin
          cnt_d   = 7'd0;
          col_d   = '0;
          state_d = S_DDIFF;
        end
      end
      S_DDIFF: begin
        cmd_o.d_diff = 1'b1;
        state_d      = S_DMUL;
      end
      S_DMUL: begin
        cmd_o.d_mul = 1'b1;
        state_d     = S_DSTORE;
      end
      S_DSTORE: begin
        cmd_o.d_store = 1'b1;
        if (col_last) begin
          state_d = S_UPDATE;
        end else begin
          col_d   = col_q + VW'(1);
          state_d = S_DDIFF;
        end
      end
      S_UPDATE: begin
        cmd_o.rd_en    = pass_rd;
        cmd_o.p_update = proc;
        cnt_d          = cnt_q + 7'd1;
        if (pass_end) begin
          cnt_d   = 7'd0;
          state_d = S_IDLE;
        end
      end
      S_QACC: begin
        cmd_o.rd_en     = pass_rd;
        cmd_o.p_acc     = proc;
        cmd_o.use_query = 1'b1;
        cmd_o.first     = (cnt_q == 7'd1);
        cnt_d           = cnt_q + 7'd1;
        if (pass_end) begin
          cnt_d   = 7'd0;
          col_d   = '0;
          state_d = S_OROUND;
        end
      end
      S_OROUND: begin
        cmd_o.o_round = 1'b1;
        state_d       = S_OMUL;
      end
      S_OMUL: begin
        cmd_o.o_mul = 1'b1;
        state_d     = S_OLOAD;
      end
      S_OLOAD: begin
        if (sts_i.out_free) begin
          cmd_o.o_load = 1'b1;
          if (col_last) begin
            state_d = S_IDLE;
          end else begin
            col_d   = col_q + VW'(1);
            state_d = S_OROUND;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= 7'd0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      col_q   <= col_d;
    end
  end

endmodule

>>> sv/lasu_dp.sv
`timescale 1ns / 1ps
// Datapath: element buffers, state matrix rows with four multipliers per column, output word.
// Depends on lasu_pkg, lasu_ram and lasu_decay.
module lasu_dp
  import lasu_pkg::*;
#(
  parameter int unsigned DK        = 16,
  parameter int unsigned DV        = 16,
  parameter int unsigned MAX_HEADS = 4
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  cmd_t                                   cmd_i,
  input  logic [((DK > 1) ? $clog2(DK) : 1)-1:0] row_rd_i,
  input  logic [((DK > 1) ? $clog2(DK) : 1)-1:0] row_proc_i,
  input  logic [((DV > 1) ? $clog2(DV) : 1)-1:0] col_i,
  input  logic [5:0]                             idx_i,
  input  logic [1:0]                             head_i,
  input  logic signed [15:0]                     elem_value_i,
  input  logic signed [15:0]                     decay_log_i,
  input  logic [15:0]                            beta_i,
  input  logic [1:0]                             rule_i,
  input  logic                                   decay_per_key_i,
  input  logic [15:0]                            scale_i,
  input  logic [6:0]                             vd_i,
  input  logic                                   out_ready_i,
  output sts_t                                   sts_o,
  output logic                                   out_valid_o,
  output logic [5:0]                             out_index_o,
  output logic [1:0]                             out_head_o,
  output logic signed [31:0]                     out_value_o,
  output logic                                   out_last_o
);

  localparam int unsigned KW    = (DK > 1) ? $clog2(DK) : 1;
  localparam int unsigned VW    = (DV > 1) ? $clog2(DV) : 1;
  localparam int unsigned QD    = MAX_HEADS * DK;
  localparam int unsigned QAW   = (QD > 1) ? $clog2(QD) : 1;
  localparam int unsigned ACC_W = 49 + KW;
  localparam int unsigned AAW   = ACC_W - 12;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic signed [15:0]      key_q [DK];
  logic [16:0]             fac_q [DK];
  logic signed [15:0]      val_q [DV];
  logic signed [31:0]      dl_q [DV];
  logic signed [ACC_W-1:0] acc_q [DV];
  logic signed [ACC_W-1:0] acc_nxt [DV];
  logic [15:0]             beta_q;
  logic [1:0]              head_q;
  logic [KW-1:0]           dec_idx_q;
  logic [DK-1:0]           row_valid_q;
  logic                    rvalid_q;
  logic signed [33:0]      diff_q;
  logic signed [50:0]      dprod_q;
  logic signed [AAW-1:0]   a_q;
  logic signed [AAW+16:0]  oprod_q;
  logic                    out_valid_q;
  logic [5:0]              out_index_q;
  logic [1:0]              out_head_q;
  logic signed [31:0]      out_value_q;
  logic                    out_last_q;

  logic                    dec_busy, dec_done;
  logic [16:0]             dec_factor;
  logic [DV*32-1:0]        ram_rdata, row_w, new_row;
  logic [15:0]             q_rdata;
  logic [QAW-1:0]          q_waddr, q_raddr;
  logic signed [15:0]      kk, mul16;
  logic [16:0]             fac_sel;
  logic                    delta;
  logic signed [ACC_W-1:0] acc_sel, a_full;
  logic signed [31:0]      r_w;

  assign delta   = (rule_i == RULE_DELTA) || (rule_i == RULE_GATED_DELTA);
  assign kk      = key_q[row_proc_i];
  assign fac_sel = decay_per_key_i ? fac_q[row_proc_i] : fac_q[0];
  assign mul16   = cmd_i.use_query ? $signed(q_rdata) : kk;
  assign row_w   = rvalid_q ? ram_rdata : '0;
  assign q_waddr = QAW'(head_i) * QAW'(DK) + QAW'(idx_i[KW-1:0]);
  assign q_raddr = QAW'(head_q) * QAW'(DK) + QAW'(row_rd_i);
  assign acc_sel = acc_q[col_i];
  assign a_full  = (acc_sel + ACC_W'(2048)) >>> 12;
  assign r_w     = sat32(64'(a_full));

  lasu_decay u_decay (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.wr_key),
    .g_i      (decay_log_i),
    .busy_o   (dec_busy),
    .done_o   (dec_done),
    .factor_o (dec_factor)
  );

  lasu_ram #(
    .WIDTH (DV * 32),
    .DEPTH (DK)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.p_decay | cmd_i.p_update),
    .waddr_i (row_proc_i),
    .wdata_i (new_row),
    .re_i    (cmd_i.rd_en),
    .raddr_i (row_rd_i),
    .rdata_o (ram_rdata)
  );

  lasu_ram #(
    .WIDTH (16),
    .DEPTH (QD)
  ) u_query_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_query),
    .waddr_i (q_waddr),
    .wdata_i (elem_value_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  for (genvar j = 0; j < DV; j++) begin : g_col
    logic signed [31:0] s_w, dsat, add_d, upd;
    logic signed [48:0] dec_p;
    logic signed [47:0] pa_w, pu_w;
    logic signed [31:0] pp_w;
    logic signed [63:0] add_w;

    assign s_w   = $signed(row_w[j*32 +: 32]);
    assign dec_p = s_w * $signed({1'b0, fac_sel});
    assign dsat  = sat32((64'(dec_p) + 64'sd32768) >>> 16);
    assign pa_w  = s_w * mul16;
    assign pu_w  = kk * dl_q[j];
    assign add_d = sat32((64'(pu_w) + 64'sd2048) >>> 12);
    assign pp_w  = kk * val_q[j];
    assign add_w = delta ? 64'(add_d) : ((64'(pp_w) + 64'sd128) >>> 8);
    assign upd   = sat32(64'(s_w) + add_w);
    assign new_row[j*32 +: 32] = (7'(j) < vd_i) ? (cmd_i.p_decay ? dsat : upd) : s_w;
    assign acc_nxt[j] = cmd_i.first ? ACC_W'(pa_w) : (acc_q[j] + ACC_W'(pa_w));
  end

  assign sts_o.dec_busy = dec_busy;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q      <= 16'd0;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_value) begin
        beta_q <= beta_i;
      end
      if (cmd_i.clr) begin
        row_valid_q <= '0;
      end else if (cmd_i.p_decay || cmd_i.p_update) begin
        row_valid_q[row_proc_i] <= 1'b1;
      end
      if (cmd_i.o_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_key) begin
      key_q[idx_i[KW-1:0]] <= elem_value_i;
      dec_idx_q            <= idx_i[KW-1:0];
    end
    if (dec_done) begin
      fac_q[dec_idx_q] <= dec_factor;
    end
    if (cmd_i.wr_value) begin
      val_q[idx_i[VW-1:0]] <= elem_value_i;
    end
    if (cmd_i.wr_query) begin
      head_q <= head_i;
    end
    if (cmd_i.rd_en) begin
      rvalid_q <= row_valid_q[row_rd_i];
    end
    if (cmd_i.p_acc) begin
      for (int j = 0; j < DV; j++) begin
        acc_q[j] <= acc_nxt[j];
      end
    end
    if (cmd_i.d_diff) begin
      diff_q <= (34'(val_q[col_i]) <<< 4) - 34'(r_w);
    end
    if (cmd_i.d_mul) begin
      dprod_q <= diff_q * $signed({1'b0, beta_q});
    end
    if (cmd_i.d_store) begin
      dl_q[col_i] <= sat32((64'(dprod_q) + 64'sd16384) >>> 15);
    end
    if (cmd_i.o_round) begin
      a_q <= a_full[AAW-1:0];
    end
    if (cmd_i.o_mul) begin
      oprod_q <= a_q * $signed({1'b0, scale_i});
    end
    if (cmd_i.o_load) begin
      out_index_q <= 6'(col_i);
      out_head_q  <= head_q;
      out_value_q <= sat32((64'(oprod_q) + 64'sd16384) >>> 15);
      out_last_q  <= (7'(col_i) == (vd_i - 7'd1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_head_o  = out_head_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

endmodule

>>> sv/linear_attention_state_update.sv
`timescale 1ns / 1ps
// Key word: the decay factor series, a multiply and a divide step per term, holds ready low.
// Last value word: one row sweep of the state RAM per pass (decay, retrieval, update as
// the rule needs) plus a difference, multiply and store step per value column for delta.
// Last query word: a row sweep, then round, multiply and load per output word as it is taken.
// Reset is asynchronous, active low; the state matrix reads as zero through per-row valid bits.
module linear_attention_state_update
  import lasu_pkg::*;
#(
  parameter int unsigned DK        = 16,
  parameter int unsigned DV        = 16,
  parameter int unsigned MAX_HEADS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // elem_index[5:0], query_head[7:6], elem_value[23:8], decay_log[39:24], beta[55:40]
  input  logic [55:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_index[5:0], out_head[7:6], out_value[39:8]
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned KW = (DK > 1) ? $clog2(DK) : 1;
  localparam int unsigned VW = (DV > 1) ? $clog2(DV) : 1;

  logic [1:0]  rule_q;
  logic        dpk_q;
  logic [6:0]  ksize_q, vsize_q;
  logic [2:0]  heads_q;
  logic [15:0] scale_q;
  logic [6:0]  kd, vd;
  logic [2:0]  hg;
  logic        in_fire, cfg_fire;
  cmd_t        cmd;
  sts_t        sts;
  logic [KW-1:0] row_rd, row_proc;
  logic [VW-1:0] col;
  logic [5:0]    o_index;
  logic [1:0]    o_head;
  logic signed [31:0] o_value;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_fire     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q  <= RULE_LINEAR;
      dpk_q   <= 1'b0;
      ksize_q <= 7'd16;
      vsize_q <= 7'd16;
      heads_q <= 3'd1;
      scale_q <= 16'd32768;
    end else if (cfg_fire) begin
      case (cfg_index_i)
        REG_RULE:          rule_q  <= cfg_data_i[1:0];
        REG_DECAY_PER_KEY: dpk_q   <= cfg_data_i[0];
        REG_KEY_SIZE:      ksize_q <= cfg_data_i[6:0];
        REG_VALUE_SIZE:    vsize_q <= cfg_data_i[6:0];
        REG_HEADS:         heads_q <= cfg_data_i[2:0];
        REG_SCALE:         scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign kd = (ksize_q == 7'd0) ? 7'd1 : ((ksize_q > 7'(DK)) ? 7'(DK) : ksize_q);
  assign vd = (vsize_q == 7'd0) ? 7'd1 : ((vsize_q > 7'(DV)) ? 7'(DV) : vsize_q);
  assign hg = (heads_q == 3'd0) ? 3'd1 :
              ((heads_q > 3'(MAX_HEADS)) ? 3'(MAX_HEADS) : heads_q);

  lasu_ctrl #(
    .DK (DK),
    .DV (DV)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .action_i   (action_e'(s_axis_tuser)),
    .idx_i      (s_axis_tdata[5:0]),
    .head_i     (s_axis_tdata[7:6]),
    .rule_i     (rule_q),
    .kd_i       (kd),
    .vd_i       (vd),
    .hg_i       (hg),
    .sts_i      (sts),
    .ready_o    (s_axis_tready),
    .cmd_o      (cmd),
    .row_rd_o   (row_rd),
    .row_proc_o (row_proc),
    .col_o      (col)
  );

  lasu_dp #(
    .DK        (DK),
    .DV        (DV),
    .MAX_HEADS (MAX_HEADS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .row_rd_i        (row_rd),
    .row_proc_i      (row_proc),
    .col_i           (col),
    .idx_i           (s_axis_tdata[5:0]),
    .head_i          (s_axis_tdata[7:6]),
    .elem_value_i    (s_axis_tdata[23:8]),
    .decay_log_i     (s_axis_tdata[39:24]),
    .beta_i          (s_axis_tdata[55:40]),
    .rule_i          (rule_q),
    .decay_per_key_i (dpk_q),
    .scale_i         (scale_q),
    .vd_i            (vd),
    .out_ready_i     (m_axis_tready),
    .sts_o           (sts),
    .out_valid_o     (m_axis_tvalid),
    .out_index_o     (o_index),
    .out_head_o      (o_head),
    .out_value_o     (o_value),
    .out_last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {o_value, o_head, o_index};

`ifndef NO_ASSERTIONS
  a_ready_not_while_factor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !sts.dec_busy)
    else $error("input ready while a decay factor is in progress");

  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.o_load |-> sts.out_free)
    else $error("output word loaded over an untaken word");

  a_no_clear_during_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr |-> !(cmd.p_decay || cmd.p_update || cmd.rd_en))
    else $error("clear overlaps a row pass");

  a_last_matches_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (7'(o_index) == vd - 7'd1))
    else $error("last word does not sit at the final value position");
`endif

endmodule
